@@ rtl/core/sma_pkg.sv @@
// shared types and constants of the stack machine arithmetic unit
`default_nettype none
package sma_pkg;
  localparam int unsigned StackDepth = 32;
  localparam int unsigned MaxChars   = 32;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [3:0] {
    MODE_PUSH  = 4'd0,
    MODE_ADD   = 4'd1,
    MODE_SUB   = 4'd2,
    MODE_DIV   = 4'd3,
    MODE_MUL   = 4'd4,
    MODE_MOD   = 4'd5,
    MODE_PCHAR = 4'd6,
    MODE_PSTR  = 4'd7,
    MODE_ROTL  = 4'd8,
    MODE_ROTR  = 4'd9
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_DIV_ZERO = 3'd2,
    ST_RANGE    = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  localparam logic [6:0] CharNewline = 7'd10;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_PUSH  = 3'd1,
    OP_ARITH = 3'd2,
    OP_PCHAR = 3'd3,
    OP_PSTR  = 3'd4,
    OP_ROTL  = 3'd5,
    OP_ROTR  = 3'd6
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [3:0]  mode;
    logic [31:0] push_value;
  } cmd_t;
endpackage
`default_nettype wire

@@ rtl/core/sma_if.sv @@
// valid/ready channel interfaces for input and result transactions
`default_nettype none
interface sma_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic signed [31:0] push_value;
  modport source (output valid, mode, push_value, input ready);
  modport sink (input valid, mode, push_value, output ready);
endinterface

interface sma_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic [2:0] status;
  logic       last;
  modport source (output valid, char_code, status, last, input ready);
  modport sink (input valid, char_code, status, last, output ready);
endinterface
`default_nettype wire

@@ rtl/core/sma_ram.sv @@
// generic single write port ram with one registered read port
`default_nettype none
module sma_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ rtl/core/sma_front.sv @@
// front end: accepts transactions, classifies the mode and queues commands
`default_nettype none
module sma_front #(
  parameter int unsigned QDepth = sma_pkg::QueueDepth
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  sma_in_if.sink       in_if,
  output logic         cmd_valid_o,
  output sma_pkg::cmd_t cmd_o,
  input  wire logic    cmd_ready_i
);
  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;

  sma_pkg::cmd_t   q_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  sma_pkg::cmd_t   cmd_new;
  logic            push, pop;

  always_comb begin
    cmd_new.mode       = in_if.mode;
    cmd_new.push_value = in_if.push_value;
    case (in_if.mode)
      sma_pkg::MODE_PUSH:  cmd_new.op = sma_pkg::OP_PUSH;
      sma_pkg::MODE_ADD, sma_pkg::MODE_SUB, sma_pkg::MODE_DIV,
      sma_pkg::MODE_MUL, sma_pkg::MODE_MOD: cmd_new.op = sma_pkg::OP_ARITH;
      sma_pkg::MODE_PCHAR: cmd_new.op = sma_pkg::OP_PCHAR;
      sma_pkg::MODE_PSTR:  cmd_new.op = sma_pkg::OP_PSTR;
      sma_pkg::MODE_ROTL:  cmd_new.op = sma_pkg::OP_ROTL;
      sma_pkg::MODE_ROTR:  cmd_new.op = sma_pkg::OP_ROTR;
      default:             cmd_new.op = sma_pkg::OP_NOP;
    endcase
  end

  assign in_if.ready = (cnt_q != (PtrW+1)'(QDepth));
  assign push        = in_if.valid && in_if.ready;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/sma_divider.sv @@
// radix-2 signed divider, one quotient bit per cycle, truncating toward zero
`default_nettype none
module sma_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic             done_o,
  output logic [31:0]      quot_o,
  output logic [31:0]      rem_o
);
  logic [31:0] ua, ub;
  logic [31:0] quo_q, div_q;
  logic [32:0] rem_q;
  logic [5:0]  cnt_q;
  logic        busy_q, nq_q, nr_q;
  logic [32:0] trial;

  assign ua    = a_i[31] ? (~a_i + 32'd1) : a_i;
  assign ub    = b_i[31] ? (~b_i + 32'd1) : b_i;
  assign trial = {rem_q[31:0], quo_q[31]} - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= ua;
      div_q <= ub;
      rem_q <= '0;
      nq_q  <= a_i[31] ^ b_i[31];
      nr_q  <= a_i[31];
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_q <= trial;
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= {rem_q[31:0], quo_q[31]};
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  // the minimum over minus one case wraps naturally through negation
  assign quot_o = nq_q ? (~quo_q + 32'd1) : quo_q;
  assign rem_o  = nr_q ? (~rem_q[31:0] + 32'd1) : rem_q[31:0];
endmodule
`default_nettype wire

@@ rtl/core/sma_back.sv @@
// back end: stack ring in ram, executes commands and emits result transactions
`default_nettype none
module sma_back #(
  parameter int unsigned Depth = sma_pkg::StackDepth
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cmd_valid_i,
  input  sma_pkg::cmd_t cmd_i,
  output logic          cmd_ready_o,
  sma_out_if.source     out_if
);
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD1   = 9'b000000010,
    S_RD2   = 9'b000000100,
    S_EXEC  = 9'b000001000,
    S_DIV   = 9'b000010000,
    S_WB    = 9'b000100000,
    S_PRD   = 9'b001000000,
    S_PCHK  = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_e;

  state_e        st_q;
  sma_pkg::cmd_t cmd_q;
  logic [AW-1:0] bot_q;
  logic [CW-1:0] cnt_q;
  logic [31:0]   top_q, sec_q, res_q;
  logic [CW-1:0] walk_q;
  logic [5:0]    nch_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  logic          ov_q;
  logic [6:0]    och_q;
  logic [2:0]    ost_q;
  logic          olast_q;
  logic          div_start, div_done;
  logic [31:0]   quot, rem;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] b, input logic [CW-1:0] i);
    logic [AW:0] s;
    s = {1'b0, b} + (AW+1)'(i);
    if (s >= (AW+1)'(Depth)) s = s - (AW+1)'(Depth);
    return s[AW-1:0];
  endfunction

  sma_ram #(.Width(32), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  sma_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .a_i(sec_q), .b_i(top_q),
    .done_o(div_done), .quot_o(quot), .rem_o(rem)
  );

  logic [AW-1:0] bot_dec, bot_inc;
  assign bot_dec = (bot_q == '0) ? AW'(Depth - 1) : bot_q - 1'b1;
  assign bot_inc = (bot_q == AW'(Depth - 1)) ? '0 : bot_q + 1'b1;

  logic out_free;
  assign out_free    = !ov_q || out_if.ready;
  assign cmd_ready_o = (st_q == S_IDLE) && out_free;
  assign out_if.valid     = ov_q;
  assign out_if.char_code = och_q;
  assign out_if.status    = ost_q;
  assign out_if.last      = olast_q;

  logic is_dm;
  assign is_dm = (cmd_q.mode == sma_pkg::MODE_DIV) || (cmd_q.mode == sma_pkg::MODE_MOD);
  assign div_start = (st_q == S_EXEC) && is_dm && (top_q != '0);

  logic pstr_ok;
  assign pstr_ok = !rdata[31] && (rdata > 32'd32) && (rdata <= 32'd126);

  // a new result transaction is loaded into the output register this cycle
  logic emit;
  always_comb begin
    emit = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          case (cmd_i.op)
            sma_pkg::OP_ARITH, sma_pkg::OP_ROTL, sma_pkg::OP_ROTR: emit = (cnt_q < CW'(2));
            sma_pkg::OP_PCHAR: emit = (cnt_q == '0);
            sma_pkg::OP_PSTR:  emit = 1'b0;
            default:           emit = 1'b1;
          endcase
        end
      end
      S_EXEC: emit = is_dm && (top_q == '0);
      S_WB, S_EMIT, S_PCHK: emit = out_free;
      default: emit = 1'b0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = slot(bot_q, cnt_q);
    wdata = cmd_i.push_value;
    raddr = slot(bot_q, cnt_q - 1'b1);
    case (st_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free && cmd_i.op == sma_pkg::OP_PUSH
            && cnt_q != CW'(Depth)) begin
          we = 1'b1;
        end
        if (cmd_i.op == sma_pkg::OP_ROTR) raddr = bot_q;
      end
      S_RD1:  raddr = slot(bot_q, cnt_q - CW'(2));
      S_WB: begin
        we = 1'b1;
        case (cmd_q.op)
          sma_pkg::OP_ARITH: begin
            waddr = slot(bot_q, cnt_q - CW'(2));
            wdata = res_q;
          end
          sma_pkg::OP_ROTL: begin
            waddr = bot_dec;
            wdata = top_q;
          end
          default: begin
            waddr = slot(bot_inc, cnt_q - 1'b1);
            wdata = top_q;
          end
        endcase
      end
      S_PRD, S_PCHK: raddr = slot(bot_q, walk_q - 1'b1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && cmd_valid_i && out_free) cmd_q <= cmd_i;
    if (st_q == S_RD1) top_q <= rdata;
    if (st_q == S_RD2) sec_q <= rdata;
    if (st_q == S_EXEC) begin
      case (cmd_q.mode)
        sma_pkg::MODE_ADD: res_q <= sec_q + top_q;
        sma_pkg::MODE_SUB: res_q <= sec_q - top_q;
        default:           res_q <= sec_q * top_q;
      endcase
    end
    if (st_q == S_DIV && div_done) begin
      res_q <= (cmd_q.mode == sma_pkg::MODE_DIV) ? quot : rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      bot_q   <= '0;
      cnt_q   <= '0;
      walk_q  <= '0;
      nch_q   <= '0;
      ov_q    <= 1'b0;
      och_q   <= '0;
      ost_q   <= '0;
      olast_q <= 1'b0;
    end else begin
      if (emit) ov_q <= 1'b1;
      else if (out_if.ready) ov_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          if (cmd_valid_i && out_free) begin
            case (cmd_i.op)
              sma_pkg::OP_PUSH: begin
                och_q <= '0; olast_q <= 1'b1;
                if (cnt_q == CW'(Depth)) ost_q <= sma_pkg::ST_FULL;
                else begin
                  ost_q <= sma_pkg::ST_OK;
                  cnt_q <= cnt_q + 1'b1;
                end
              end
              sma_pkg::OP_ARITH: begin
                if (cnt_q < CW'(2)) begin
                  och_q <= '0; olast_q <= 1'b1;
                  ost_q <= sma_pkg::ST_SHORT;
                end else st_q <= S_RD1;
              end
              sma_pkg::OP_PCHAR: begin
                if (cnt_q == '0) begin
                  och_q <= '0; olast_q <= 1'b1;
                  ost_q <= sma_pkg::ST_SHORT;
                end else st_q <= S_RD1;
              end
              sma_pkg::OP_PSTR: begin
                walk_q <= cnt_q;
                nch_q  <= '0;
                st_q   <= S_PRD;
              end
              sma_pkg::OP_ROTL, sma_pkg::OP_ROTR: begin
                if (cnt_q < CW'(2)) begin
                  och_q <= '0; olast_q <= 1'b1;
                  ost_q <= sma_pkg::ST_OK;
                end else st_q <= S_RD1;
              end
              default: begin
                och_q <= '0; olast_q <= 1'b1;
                ost_q <= sma_pkg::ST_OK;
              end
            endcase
          end
        end
        S_RD1: begin
          // top (or bottom for rotr) word now on the read port
          if (cmd_q.op == sma_pkg::OP_ARITH) st_q <= S_RD2;
          else if (cmd_q.op == sma_pkg::OP_PCHAR) st_q <= S_EMIT;
          else st_q <= S_WB;
        end
        S_RD2: st_q <= S_EXEC;
        S_EXEC: begin
          if (is_dm) begin
            if (top_q == '0) begin
              och_q <= '0; olast_q <= 1'b1;
              ost_q <= sma_pkg::ST_DIV_ZERO;
              st_q <= S_IDLE;
            end else st_q <= S_DIV;
          end else st_q <= S_WB;
        end
        S_DIV: if (div_done) st_q <= S_WB;
        S_WB: begin
          if (out_free) begin
            och_q <= '0; olast_q <= 1'b1;
            ost_q <= sma_pkg::ST_OK;
            case (cmd_q.op)
              sma_pkg::OP_ARITH: cnt_q <= cnt_q - 1'b1;
              sma_pkg::OP_ROTL:  bot_q <= bot_dec;
              default:           bot_q <= bot_inc;
            endcase
            st_q <= S_IDLE;
          end
        end
        S_EMIT: begin
          // pchar: top_q holds the top entry
          if (out_free) begin
            if (top_q[31] || top_q == '0 || top_q > 32'd126) begin
              och_q <= '0; ost_q <= sma_pkg::ST_RANGE; olast_q <= 1'b1;
              st_q <= S_IDLE;
            end else if (nch_q == '0) begin
              och_q <= top_q[6:0]; ost_q <= sma_pkg::ST_OK; olast_q <= 1'b0;
              nch_q <= 6'd1;
            end else begin
              och_q <= sma_pkg::CharNewline; ost_q <= sma_pkg::ST_OK; olast_q <= 1'b1;
              nch_q <= '0;
              st_q <= S_IDLE;
            end
          end
        end
        S_PRD: st_q <= S_PCHK;
        S_PCHK: begin
          // one character per visit, read of next entry issued on return
          if (out_free) begin
            ost_q <= sma_pkg::ST_OK;
            if (walk_q != '0 && nch_q != 6'(sma_pkg::MaxChars) && pstr_ok) begin
              och_q <= rdata[6:0]; olast_q <= 1'b0;
              walk_q <= walk_q - 1'b1;
              nch_q <= nch_q + 1'b1;
              st_q <= S_PRD;
            end else begin
              och_q <= sma_pkg::CharNewline; olast_q <= 1'b1;
              nch_q <= '0;
              st_q <= S_IDLE;
            end
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/stack_machine_alu_top.sv @@
// stack machine arithmetic unit: front queue, stack executor, serial divider
// div and mod run through the 32-step serial divider
// pstr: reads each emitted character over the single ram read port, up to 33 results
// throughput: one transaction at a time in the executor, a 2-entry queue decouples input
// reset: asynchronous active low, empties the stack; ram contents are not cleared
`default_nettype none
module stack_machine_alu_top #(
  parameter int unsigned STACK_DEPTH = sma_pkg::StackDepth
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  sma_in_if.sink   in_if,
  sma_out_if.source out_if
);
  logic          cmd_valid, cmd_ready;
  sma_pkg::cmd_t cmd;

  sma_front u_front (
    .clk_i, .rst_ni, .in_if(in_if),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_ready_i(cmd_ready)
  );

  sma_back #(.Depth(STACK_DEPTH)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd),
    .cmd_ready_o(cmd_ready), .out_if(out_if)
  );
endmodule
`default_nettype wire

@@ test/sma_checker.sv @@
// checker: watches both channels, predicts stack results and compares them
module sma_checker (
  input  logic      clk_i,
  input  logic      rst_ni,
  sma_in_if.sink    in_if,
  sma_out_if.sink   out_if,
  output int        fail_cnt_o,
  output int        pending_o
);
  import sma_pkg::*;

  typedef struct packed {
    logic [6:0] char_code;
    logic [2:0] status;
    logic       last;
  } res_t;

  logic [31:0] stk_mem [StackDepth];
  int unsigned bot_idx;
  int unsigned depth_cnt;
  res_t        exp_q[$];

  function automatic int unsigned slot(int unsigned i);
    return (bot_idx + i) % StackDepth;
  endfunction

  function automatic logic [31:0] arith(logic [3:0] m, logic [31:0] a, logic [31:0] b);
    if (m == MODE_ADD) return a + b;
    if (m == MODE_SUB) return a - b;
    if (m == MODE_MUL) return a * b;
    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return (m == MODE_DIV) ? a : 32'd0;
    if (m == MODE_DIV) return $signed(a) / $signed(b);
    return $signed(a) % $signed(b);
  endfunction

  task automatic push_res(logic [6:0] c, status_e s, logic l);
    res_t r;
    r.char_code = c;
    r.status = s;
    r.last = l;
    exp_q.push_back(r);
  endtask

  task automatic predict(logic [3:0] m, logic [31:0] pv);
    logic [31:0] v;
    int unsigned i;
    int unsigned k;
    case (m)
      MODE_PUSH: begin
        if (depth_cnt >= StackDepth) push_res(0, ST_FULL, 1);
        else begin
          stk_mem[slot(depth_cnt)] = pv;
          depth_cnt++;
          push_res(0, ST_OK, 1);
        end
      end
      MODE_ADD, MODE_SUB, MODE_DIV, MODE_MUL, MODE_MOD: begin
        if (depth_cnt < 2) push_res(0, ST_SHORT, 1);
        else if ((m == MODE_DIV || m == MODE_MOD) && stk_mem[slot(depth_cnt - 1)] == 0)
          push_res(0, ST_DIV_ZERO, 1);
        else begin
          stk_mem[slot(depth_cnt - 2)] =
            arith(m, stk_mem[slot(depth_cnt - 2)], stk_mem[slot(depth_cnt - 1)]);
          depth_cnt--;
          push_res(0, ST_OK, 1);
        end
      end
      MODE_PCHAR: begin
        if (depth_cnt == 0) push_res(0, ST_SHORT, 1);
        else begin
          v = stk_mem[slot(depth_cnt - 1)];
          if (v[31] || v < 1 || v > 126) push_res(0, ST_RANGE, 1);
          else begin
            push_res(v[6:0], ST_OK, 0);
            push_res(CharNewline, ST_OK, 1);
          end
        end
      end
      MODE_PSTR: begin
        i = depth_cnt;
        k = 0;
        while (i > 0 && k < MaxChars) begin
          v = stk_mem[slot(i - 1)];
          if (v[31] || v <= 32 || v > 126) break;
          push_res(v[6:0], ST_OK, 0);
          k++;
          i--;
        end
        push_res(CharNewline, ST_OK, 1);
      end
      MODE_ROTL: begin
        if (depth_cnt >= 2) begin
          v = stk_mem[slot(depth_cnt - 1)];
          bot_idx = (bot_idx + StackDepth - 1) % StackDepth;
          stk_mem[bot_idx] = v;
        end
        push_res(0, ST_OK, 1);
      end
      MODE_ROTR: begin
        if (depth_cnt >= 2) begin
          v = stk_mem[bot_idx];
          bot_idx = (bot_idx + 1) % StackDepth;
          stk_mem[slot(depth_cnt - 1)] = v;
        end
        push_res(0, ST_OK, 1);
      end
      default: push_res(0, ST_OK, 1);
    endcase
  endtask

  assign pending_o = exp_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      bot_idx <= 0;
      depth_cnt <= 0;
      fail_cnt_o <= 0;
    end else begin
      if (in_if.valid && in_if.ready) predict(in_if.mode, in_if.push_value);
      if (out_if.valid && out_if.ready) begin
        if (exp_q.size() == 0) begin
          $display("%0t: unexpected result chr=%0d st=%0d last=%0d", $time,
                   out_if.char_code, out_if.status, out_if.last);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = exp_q.pop_front();
          if (want.char_code !== out_if.char_code || want.status !== out_if.status ||
              want.last !== out_if.last) begin
            $display("%0t: mismatch exp chr=%0d st=%0d last=%0d act chr=%0d st=%0d last=%0d",
                     $time, want.char_code, want.status, want.last,
                     out_if.char_code, out_if.status, out_if.last);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
    end
  end
endmodule

@@ test/tb.sv @@
// testbench top: drives stack operations, applies back pressure, gives the verdict
module tb;
  import sma_pkg::*;

  localparam int WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt;
  int   pending;
  int   idle_cyc;
  int   hold_cnt;
  bit   no_idle;
  bit   stim_done;
  int   depth_est;

  sma_in_if  in_if ();
  sma_out_if out_if ();

  stack_machine_alu_top u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  sma_checker u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_if.sink),
    .out_if    (out_if.sink),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending)
  );

  always #5 clk_i = ~clk_i;

  // receiver: random stalls, one long hold while hold_cnt runs
  initial out_if.ready = 1'b0;
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= no_idle || ($urandom_range(99) >= 31);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc > WatchLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // valid stays high on return; drain takes it down, the next send only in its random idle gaps
  task automatic send(logic [3:0] m, logic [31:0] pv);
    while (!no_idle && $urandom_range(99) < 31) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= m;
    in_if.push_value <= pv;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (m == MODE_PUSH && depth_est < 32) depth_est++;
    if (m >= MODE_ADD && m <= MODE_MOD && depth_est > 1) depth_est--;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5))
      0: return $urandom_range(33, 126);
      1: return $urandom_range(3) - 1;
      2: return {1'($urandom_range(1)), 31'h0} | 32'($urandom_range(1));
      3: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n;
    hold_cnt = 0;
    no_idle = 0;
    stim_done = 0;
    idle_cyc = 0;
    depth_est = 0;
    in_if.valid = 1'b0;
    in_if.mode = MODE_PUSH;
    in_if.push_value = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty-stack errors, extremes, division corners
    send(MODE_ADD, 0);
    send(MODE_PCHAR, 0);
    send(MODE_PSTR, 0);
    send(MODE_ROTL, 0);
    send(MODE_ROTR, 0);
    send(4'd15, 32'hFFFF_FFFF);
    send(MODE_PUSH, 32'h8000_0000);
    send(MODE_PUSH, 32'hFFFF_FFFF);
    send(MODE_DIV, 0);
    send(MODE_PUSH, 32'hFFFF_FFFF);
    send(MODE_MOD, 0);
    send(MODE_PUSH, 0);
    send(MODE_DIV, 0);
    send(MODE_MOD, 0);
    send(MODE_PUSH, 32'h7FFF_FFFF);
    send(MODE_MUL, 0);
    send(MODE_PUSH, 7);
    send(MODE_SUB, 0);
    send(MODE_PCHAR, 0);
    send(MODE_PUSH, 126);
    send(MODE_PCHAR, 0);
    send(MODE_PUSH, 127);
    send(MODE_PCHAR, 0);
    send(MODE_ROTR, 0);
    send(MODE_ROTL, 0);
    drain();

    // push printables past the stack's depth to overflow it, then pstr the printables on top
    no_idle = 1;
    for (int i = 0; i < 36; i++) send(MODE_PUSH, $urandom_range(33, 126));
    send(MODE_PSTR, 0);
    // long receiver hold while the sender keeps offering
    hold_cnt = 300;
    for (int i = 0; i < 10; i++) send(MODE_PCHAR, 0);
    no_idle = 0;
    drain();

    for (int it = 0; it < 480; it++) begin
      n = $urandom_range(99);
      if (n < 30 && depth_est < 32) send(MODE_PUSH, rand_val());
      else if (n < 60) send(4'($urandom_range(MODE_ADD, MODE_MOD)), $urandom);
      else if (n < 70) send(MODE_PCHAR, $urandom);
      else if (n < 78) send(MODE_PSTR, $urandom);
      else if (n < 86) send(MODE_ROTL, $urandom);
      else if (n < 94) send(MODE_ROTR, $urandom);
      else if (n < 97) send(4'($urandom_range(10, 15)), $urandom);
      else send(MODE_PUSH, rand_val());
      if (it == 200) drain();
      if (it == 300) no_idle = 1;
      if (it == 360) no_idle = 0;
    end
    drain();
    repeat (60) @(negedge clk_i);
    if (fail_cnt == 0 && pending == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule
